// ===== src/padt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the page access and dirty tracker: sizes, function codes, item types,
// controller states and the command and status bundles. Depends on nothing.
package padt_pkg;

    localparam int PAGE_SLOTS = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int ROW_BITS   = 64;
    localparam int ROWS       = PAGE_SLOTS / ROW_BITS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int BIT_W      = $clog2(ROW_BITS);
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int BYTES_W    = 25;
    localparam int ADDR_W     = 64;
    localparam int PADDR_W    = 4;
    localparam int DATA_W     = 64;

    localparam logic [BYTES_W-1:0] CAP_BYTES = BYTES_W'(longint'(PAGE_SLOTS) << PAGE_SHIFT);

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_BYTES = 1'b1;

    typedef enum logic [2:0] {
        FN_MARK_ACC   = 3'd0,
        FN_MARK_DIRTY = 3'd1,
        FN_QUERY      = 3'd2,
        FN_FIND       = 3'd3,
        FN_CLR_DIRTY  = 3'd4,
        FN_CLR_ALL    = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]        func;
        logic [ADDR_W-1:0] page_address;
        logic [IDX_W-1:0]  start_index;
    } t_item;

    typedef struct packed {
        logic              in_range;
        logic              page_accessed;
        logic              page_dirty;
        logic              found;
        logic [IDX_W-1:0]  found_index;
        logic [ADDR_W-1:0] found_address;
        logic [CNT_W-1:0]  dirty_total;
        logic [CNT_W-1:0]  tracked_pages;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_UPDATE,
        S_SEARCH,
        S_CLEAR,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic capture;
        logic decode;
        logic rd_mark;
        logic row_clr;
        logic row_start;
        logic row_inc;
        logic wr_upd;
        logic wr_zero_acc;
        logic wr_zero_dirty;
        logic found_set;
        logic cnt_clr;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic is_mark;
        logic is_find;
        logic is_clear;
        logic is_clr_all;
        logic start_out;
        logic sweep_last;
        logic row_hit;
        logic row_last;
    } t_stat;

endpackage

// ===== src/padt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module padt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/padt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the page tracker: sequences marks, searches and sweeps.
// Depends on padt_pkg.
module padt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  padt_pkg::t_stat i_stat,
    output logic           o_busy,
    output padt_pkg::t_cmd  o_cmd
);

    padt_pkg::t_state r_state;
    padt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= padt_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_stat.cfg_wr) begin
            n_state = padt_pkg::S_INIT;
        end else begin
            unique case (r_state)
                padt_pkg::S_INIT: begin
                    if (i_stat.sweep_last) n_state = padt_pkg::S_IDLE;
                end
                padt_pkg::S_IDLE: begin
                    if (i_start) n_state = padt_pkg::S_DECODE;
                end
                padt_pkg::S_DECODE: begin
                    priority if (i_stat.is_mark) begin
                        n_state = padt_pkg::S_UPDATE;
                    end else if (i_stat.is_find) begin
                        n_state = i_stat.start_out ? padt_pkg::S_REPORT : padt_pkg::S_SEARCH;
                    end else if (i_stat.is_clear) begin
                        n_state = padt_pkg::S_CLEAR;
                    end else begin
                        n_state = padt_pkg::S_REPORT;
                    end
                end
                padt_pkg::S_UPDATE: n_state = padt_pkg::S_IDLE;
                padt_pkg::S_SEARCH: begin
                    if (i_stat.row_hit || i_stat.row_last) n_state = padt_pkg::S_REPORT;
                end
                padt_pkg::S_CLEAR: begin
                    if (i_stat.sweep_last) n_state = padt_pkg::S_REPORT;
                end
                padt_pkg::S_REPORT: n_state = padt_pkg::S_IDLE;
                default: n_state = padt_pkg::S_INIT;
            endcase
        end
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_cmd.row_clr = i_stat.cfg_wr;
        o_cmd.cnt_clr = i_stat.cfg_wr;
        unique case (r_state)
            padt_pkg::S_INIT: begin
                o_cmd.row_inc       = 1'b1;
                o_cmd.wr_zero_acc   = 1'b1;
                o_cmd.wr_zero_dirty = 1'b1;
            end
            padt_pkg::S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            padt_pkg::S_DECODE: begin
                o_cmd.decode    = 1'b1;
                o_cmd.rd_mark   = i_stat.is_mark;
                o_cmd.row_start = i_stat.is_find;
                if (i_stat.is_clear) begin
                    o_cmd.row_clr = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                end
            end
            padt_pkg::S_UPDATE: begin
                o_cmd.wr_upd      = 1'b1;
                o_cmd.load_result = 1'b1;
            end
            padt_pkg::S_SEARCH: begin
                o_cmd.found_set = i_stat.row_hit;
                o_cmd.row_inc   = !i_stat.row_hit && !i_stat.row_last;
            end
            padt_pkg::S_CLEAR: begin
                o_cmd.row_inc       = 1'b1;
                o_cmd.wr_zero_acc   = i_stat.is_clr_all;
                o_cmd.wr_zero_dirty = 1'b1;
            end
            padt_pkg::S_REPORT: begin
                o_cmd.load_result = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

// ===== src/padt_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the page tracker: region registers, bitmap RAMs, row walker, dirty counter
// and result register. Depends on padt_pkg and padt_ram.
module padt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  padt_pkg::t_item                     i_item,
    input  padt_pkg::t_cmd                      i_cmd,
    output padt_pkg::t_stat                     o_stat,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [padt_pkg::PADDR_W-1:0]        i_paddr,
    input  logic [padt_pkg::DATA_W-1:0]         i_pwdata,
    output logic [padt_pkg::DATA_W-1:0]         o_prdata,
    output padt_pkg::t_result                   o_result,
    output logic                                o_result_valid
);

    localparam logic [padt_pkg::ROW_BITS-1:0] ONES = '1;

    padt_pkg::t_item                       r_item;
    logic [padt_pkg::ADDR_W-1:0]           r_base;
    logic [padt_pkg::BYTES_W-1:0]          r_bytes;
    logic [padt_pkg::ROW_W-1:0]            r_row;
    logic [padt_pkg::ROW_W-1:0]            n_row;
    logic [padt_pkg::ROW_W-1:0]            r_mrow;
    logic [padt_pkg::BIT_W-1:0]            r_bit;
    logic                                  r_in_range;
    logic                                  r_found;
    logic [padt_pkg::IDX_W-1:0]            r_found_idx;
    logic [padt_pkg::CNT_W-1:0]            r_cnt;
    logic [padt_pkg::CNT_W-1:0]            n_cnt;
    padt_pkg::t_result                     r_result;
    padt_pkg::t_result                     n_result;
    logic                                  r_result_valid;

    logic                                  cfg_wr;
    logic [padt_pkg::BYTES_W-1:0]          wr_bytes;
    logic [padt_pkg::BYTES_W:0]            bytes_up;
    logic [padt_pkg::CNT_W-1:0]            pages;
    logic [padt_pkg::CNT_W-1:0]            pages_m1;
    logic [padt_pkg::ADDR_W:0]             diff;
    logic                                  addr_in;
    logic [padt_pkg::IDX_W-1:0]            mark_idx;
    logic                                  is_mark;
    logic                                  is_acc_mark;
    logic                                  is_dirty_mark;

    logic                                  acc_we;
    logic                                  dirty_we;
    logic [padt_pkg::ROW_W-1:0]            waddr;
    logic [padt_pkg::ROW_W-1:0]            raddr;
    logic [padt_pkg::ROW_BITS-1:0]         acc_wdata;
    logic [padt_pkg::ROW_BITS-1:0]         dirty_wdata;
    logic [padt_pkg::ROW_BITS-1:0]         acc_rdata;
    logic [padt_pkg::ROW_BITS-1:0]         dirty_rdata;
    logic [padt_pkg::ROW_BITS-1:0]         upd_mask;
    logic                                  old_acc;
    logic                                  old_dirty;

    logic [padt_pkg::ROW_W-1:0]            first_row;
    logic [padt_pkg::ROW_W-1:0]            last_row;
    logic [padt_pkg::ROW_BITS-1:0]         lo_mask;
    logic [padt_pkg::ROW_BITS-1:0]         hi_mask;
    logic [padt_pkg::ROW_BITS-1:0]         hits;
    logic [padt_pkg::BIT_W-1:0]            enc;

    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign wr_bytes = (i_pwdata[padt_pkg::BYTES_W-1:0] > padt_pkg::CAP_BYTES)
                      ? padt_pkg::CAP_BYTES : i_pwdata[padt_pkg::BYTES_W-1:0];
    assign o_prdata = (i_paddr[3] == padt_pkg::REG_BYTES)
                      ? padt_pkg::DATA_W'(r_bytes) : r_base;

    assign bytes_up = {1'b0, r_bytes} + (padt_pkg::BYTES_W + 1)'((1 << padt_pkg::PAGE_SHIFT) - 1);
    assign pages    = padt_pkg::CNT_W'(bytes_up >> padt_pkg::PAGE_SHIFT);
    assign pages_m1 = pages - padt_pkg::CNT_W'(1);

    assign diff     = {1'b0, r_item.page_address} - {1'b0, r_base};
    assign addr_in  = !diff[padt_pkg::ADDR_W]
                      && (diff[padt_pkg::ADDR_W-1:padt_pkg::BYTES_W] == '0)
                      && (diff[padt_pkg::BYTES_W-1:0] < r_bytes);
    assign mark_idx = diff[padt_pkg::PAGE_SHIFT+padt_pkg::IDX_W-1:padt_pkg::PAGE_SHIFT];

    assign is_acc_mark   = (r_item.func == padt_pkg::FN_MARK_ACC);
    assign is_dirty_mark = (r_item.func == padt_pkg::FN_MARK_DIRTY);
    assign is_mark       = is_acc_mark || is_dirty_mark || (r_item.func == padt_pkg::FN_QUERY);

    always_comb begin
        priority if (i_cmd.row_clr) begin
            n_row = '0;
        end else if (i_cmd.row_start) begin
            n_row = r_item.start_index[padt_pkg::IDX_W-1:padt_pkg::BIT_W];
        end else if (i_cmd.row_inc) begin
            n_row = r_row + padt_pkg::ROW_W'(1);
        end else begin
            n_row = r_row;
        end
    end

    assign raddr     = i_cmd.rd_mark ? mark_idx[padt_pkg::IDX_W-1:padt_pkg::BIT_W] : n_row;
    assign waddr     = i_cmd.wr_upd ? r_mrow : r_row;
    assign upd_mask  = padt_pkg::ROW_BITS'(1) << r_bit;
    assign old_acc   = acc_rdata[r_bit];
    assign old_dirty = dirty_rdata[r_bit];

    assign acc_we      = (i_cmd.wr_upd && r_in_range && (is_acc_mark || is_dirty_mark))
                         || i_cmd.wr_zero_acc;
    assign dirty_we    = (i_cmd.wr_upd && r_in_range && is_dirty_mark) || i_cmd.wr_zero_dirty;
    assign acc_wdata   = i_cmd.wr_zero_acc ? '0 : (acc_rdata | upd_mask);
    assign dirty_wdata = i_cmd.wr_zero_dirty ? '0 : (dirty_rdata | upd_mask);

    padt_ram #(
        .WIDTH (padt_pkg::ROW_BITS),
        .DEPTH (padt_pkg::ROWS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (waddr),
        .i_wdata (acc_wdata),
        .i_raddr (raddr),
        .o_rdata (acc_rdata)
    );

    padt_ram #(
        .WIDTH (padt_pkg::ROW_BITS),
        .DEPTH (padt_pkg::ROWS)
    ) u_dirty_ram (
        .i_clk   (i_clk),
        .i_we    (dirty_we),
        .i_waddr (waddr),
        .i_wdata (dirty_wdata),
        .i_raddr (raddr),
        .o_rdata (dirty_rdata)
    );

    assign first_row = r_item.start_index[padt_pkg::IDX_W-1:padt_pkg::BIT_W];
    assign last_row  = pages_m1[padt_pkg::IDX_W-1:padt_pkg::BIT_W];
    assign lo_mask   = (r_row == first_row)
                       ? (ONES << r_item.start_index[padt_pkg::BIT_W-1:0]) : ONES;
    assign hi_mask   = (r_row == last_row)
                       ? (ONES >> (padt_pkg::BIT_W'(padt_pkg::ROW_BITS - 1)
                                   - pages_m1[padt_pkg::BIT_W-1:0])) : ONES;
    assign hits      = dirty_rdata & lo_mask & hi_mask;

    always_comb begin
        enc = '0;
        for (int j = padt_pkg::ROW_BITS - 1; j >= 0; j--) begin
            if (hits[j]) enc = padt_pkg::BIT_W'(j);
        end
    end

    always_comb begin
        priority if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.wr_upd && r_in_range && is_dirty_mark && !old_dirty) begin
            n_cnt = r_cnt + padt_pkg::CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_comb begin
        n_result               = '0;
        n_result.in_range      = r_in_range;
        n_result.page_accessed = r_in_range && ((is_acc_mark || is_dirty_mark) || old_acc);
        n_result.page_dirty    = r_in_range && (is_dirty_mark || old_dirty);
        n_result.found         = r_found;
        n_result.found_index   = r_found ? r_found_idx : '0;
        n_result.found_address = r_found
            ? (r_base + padt_pkg::ADDR_W'({r_found_idx, {padt_pkg::PAGE_SHIFT{1'b0}}})) : '0;
        n_result.dirty_total   = n_cnt;
        n_result.tracked_pages = pages;
    end

    assign o_stat.cfg_wr     = cfg_wr;
    assign o_stat.is_mark    = is_mark;
    assign o_stat.is_find    = (r_item.func == padt_pkg::FN_FIND);
    assign o_stat.is_clear   = (r_item.func == padt_pkg::FN_CLR_DIRTY)
                               || (r_item.func == padt_pkg::FN_CLR_ALL);
    assign o_stat.is_clr_all = (r_item.func == padt_pkg::FN_CLR_ALL);
    assign o_stat.start_out  = ({1'b0, r_item.start_index} >= pages);
    assign o_stat.sweep_last = (r_row == padt_pkg::ROW_W'(padt_pkg::ROWS - 1));
    assign o_stat.row_hit    = |hits;
    assign o_stat.row_last   = (r_row == last_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base         <= '0;
            r_bytes        <= '0;
            r_row          <= '0;
            r_cnt          <= '0;
            r_in_range     <= 1'b0;
            r_found        <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            if (cfg_wr && (i_paddr[3] == padt_pkg::REG_BASE)) r_base <= i_pwdata;
            if (cfg_wr && (i_paddr[3] == padt_pkg::REG_BYTES)) r_bytes <= wr_bytes;
            r_row          <= n_row;
            r_cnt          <= n_cnt;
            r_result_valid <= i_cmd.load_result;
            if (i_cmd.capture) begin
                r_in_range <= 1'b0;
                r_found    <= 1'b0;
            end else begin
                if (i_cmd.decode) r_in_range <= is_mark && addr_in;
                if (i_cmd.found_set) r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.decode) begin
            r_mrow <= mark_idx[padt_pkg::IDX_W-1:padt_pkg::BIT_W];
            r_bit  <= mark_idx[padt_pkg::BIT_W-1:0];
        end
        if (i_cmd.capture) begin
            r_found_idx <= '0;
        end else if (i_cmd.found_set) begin
            r_found_idx <= {r_row, enc};
        end
        if (i_cmd.load_result) r_result <= n_result;
    end

    assign o_result       = r_result;
    assign o_result_valid = r_result_valid;

endmodule

// ===== src/page_access_dirty_tracker_core.sv =====
`timescale 1ns / 1ps
// Top level of the page access and dirty tracker: controller, datapath and APB port.
// Depends on padt_pkg, padt_ctrl and padt_dp.
// Mark and query items keep busy high from accept until the result appears.
// Find-next scans 64-page bitmap rows from the start row to a hit or the last tracked row.
// Clear-dirty and clear-all walk all 64 RAM rows.
// After reset and after every register write a clearing pass over all rows keeps busy high.
// Results show for one cycle on o_result_valid; the receiver cannot stall them.
module page_access_dirty_tracker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  padt_pkg::t_item                 i_item,
    output padt_pkg::t_result               o_result,
    output logic                            o_result_valid,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [padt_pkg::PADDR_W-1:0]    paddr,
    input  logic [padt_pkg::DATA_W-1:0]     pwdata,
    output logic [padt_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    padt_pkg::t_cmd  cmd;
    padt_pkg::t_stat stat;

    assign pready = 1'b1;

    padt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    padt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

// ===== src/padt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the page tracker top level, attached by bind.
// Depends on padt_pkg and page_access_dirty_tracker_core.
module padt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input padt_pkg::t_result o_result,
    input logic              o_result_valid
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.found) |->
            (o_result.found_index == '0) && (o_result.found_address == '0))
        else $error("found fields set without a found page");

    a_dirty_implies_accessed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.page_dirty) |->
            (o_result.page_accessed && o_result.in_range))
        else $error("dirty page reported without accessed or in-range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.dirty_total <= o_result.tracked_pages))
        else $error("dirty count exceeds tracked pages");

endmodule

bind page_access_dirty_tracker_core padt_checker u_padt_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for page_access_dirty_tracker_core: directed and random items
// checked against an in-bench bitmap tracker, with region registers set over APB.
// Depends on padt_pkg and the tracker RTL.
module testbench;

    localparam logic [padt_pkg::PADDR_W-1:0] ADDR_REGION_BASE  = 4'h0;
    localparam logic [padt_pkg::PADDR_W-1:0] ADDR_REGION_BYTES = 4'h8;
    localparam logic [2:0]                   FN_SPARE_6        = 3'd6;
    localparam logic [2:0]                   FN_SPARE_7        = 3'd7;
    localparam int                           CYCLE_LIMIT       = 300000;
    localparam int                           REPORT_MAX        = 10;
    localparam int                           PHASE_ITEMS       = 75;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    padt_pkg::t_item                     item_in;
    padt_pkg::t_result                   result;
    logic                                result_valid;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [padt_pkg::PADDR_W-1:0]        paddr;
    logic [padt_pkg::DATA_W-1:0]         pwdata;
    logic [padt_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    logic [padt_pkg::ADDR_W-1:0]         trk_base;
    logic [padt_pkg::BYTES_W-1:0]        trk_bytes;
    bit                                  acc_map [padt_pkg::PAGE_SLOTS];
    bit                                  dirty_map [padt_pkg::PAGE_SLOTS];
    logic [padt_pkg::CNT_W-1:0]          dirty_cnt;

    padt_pkg::t_result                   expected_q [$];
    int                                  errors;
    int                                  cycles;
    bit                                  no_gaps;

    page_access_dirty_tracker_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item_in),
        .o_result       (result),
        .o_result_valid (result_valid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [padt_pkg::ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned page_total();
        logic [padt_pkg::BYTES_W:0] sum;
        sum = {1'b0, trk_bytes}
              + (padt_pkg::BYTES_W+1)'((1 << padt_pkg::PAGE_SHIFT) - 1);
        return int'(sum >> padt_pkg::PAGE_SHIFT);
    endfunction

    function automatic void clear_maps(bit keep_accessed);
        foreach (dirty_map[k]) begin
            dirty_map[k] = 1'b0;
            if (!keep_accessed) acc_map[k] = 1'b0;
        end
        dirty_cnt = '0;
    endfunction

    function automatic padt_pkg::t_result track_step(padt_pkg::t_item it);
        padt_pkg::t_result           r;
        logic [padt_pkg::ADDR_W-1:0] off;
        int unsigned                 idx;
        int unsigned                 pages;
        int unsigned                 i;
        r = '0;
        pages = page_total();
        if (it.func <= padt_pkg::FN_QUERY) begin
            off = it.page_address - trk_base;
            if (it.page_address >= trk_base && off < padt_pkg::ADDR_W'(trk_bytes)) begin
                idx = int'(off >> padt_pkg::PAGE_SHIFT);
                r.in_range = 1'b1;
                if (it.func == padt_pkg::FN_MARK_ACC) begin
                    acc_map[idx] = 1'b1;
                end else if (it.func == padt_pkg::FN_MARK_DIRTY) begin
                    if (!dirty_map[idx]) dirty_cnt = dirty_cnt + 1'b1;
                    dirty_map[idx] = 1'b1;
                    acc_map[idx] = 1'b1;
                end
                r.page_accessed = acc_map[idx];
                r.page_dirty    = dirty_map[idx];
            end
        end else if (it.func == padt_pkg::FN_FIND) begin
            for (i = it.start_index; i < pages && i < padt_pkg::PAGE_SLOTS && !r.found;
                 i++) begin
                if (dirty_map[i]) begin
                    r.found         = 1'b1;
                    r.found_index   = padt_pkg::IDX_W'(i);
                    r.found_address = trk_base
                                      + (padt_pkg::ADDR_W'(i) << padt_pkg::PAGE_SHIFT);
                end
            end
        end else if (it.func == padt_pkg::FN_CLR_DIRTY) begin
            clear_maps(1'b1);
        end else if (it.func == padt_pkg::FN_CLR_ALL) begin
            clear_maps(1'b0);
        end
        r.dirty_total   = dirty_cnt;
        r.tracked_pages = padt_pkg::CNT_W'(pages);
        return r;
    endfunction

    function automatic padt_pkg::t_item mk_item(logic [2:0] func,
                                                logic [padt_pkg::ADDR_W-1:0] addr,
                                                logic [padt_pkg::IDX_W-1:0] first);
        padt_pkg::t_item it;
        it.func         = func;
        it.page_address = addr;
        it.start_index  = first;
        return it;
    endfunction

    always @(posedge i_clk) begin
        padt_pkg::t_result exp_r;
        if (i_rst_n && result_valid) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result %p", result);
            end else begin
                exp_r = expected_q.pop_front();
                if (result.in_range !== exp_r.in_range ||
                    result.page_accessed !== exp_r.page_accessed ||
                    result.page_dirty !== exp_r.page_dirty ||
                    result.found !== exp_r.found ||
                    result.found_index !== exp_r.found_index ||
                    result.found_address !== exp_r.found_address ||
                    result.dirty_total !== exp_r.dirty_total ||
                    result.tracked_pages !== exp_r.tracked_pages) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("mismatch: expected %p, actual %p", exp_r, result);
                end
            end
        end
    end

    task automatic send_item(input padt_pkg::t_item it);
        int                gap;
        int                r;
        padt_pkg::t_result exp_r;
        item_in <= it;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_r = track_step(it);
        expected_q.insert(expected_q.size(), exp_r);
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic [padt_pkg::PADDR_W-1:0] addr,
                              input logic [padt_pkg::DATA_W-1:0] value,
                              input logic is_write);
        while (busy) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [padt_pkg::PADDR_W-1:0] addr,
                             input logic [padt_pkg::DATA_W-1:0] value);
        apb_access(addr, value, 1'b1);
        if (addr == ADDR_REGION_BASE)
            trk_base = value;
        else
            trk_bytes = (value[padt_pkg::BYTES_W-1:0] > padt_pkg::CAP_BYTES)
                        ? padt_pkg::CAP_BYTES : value[padt_pkg::BYTES_W-1:0];
        clear_maps(1'b0);
    endtask

    task automatic check_reg(input logic [padt_pkg::PADDR_W-1:0] addr);
        logic [padt_pkg::DATA_W-1:0] want;
        want = (addr == ADDR_REGION_BASE) ? trk_base : padt_pkg::DATA_W'(trk_bytes);
        apb_access(addr, '0, 1'b0);
        if (prdata !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("register %h read: expected %h, actual %h", addr, want, prdata);
        end
    endtask

    task automatic set_region(input logic [padt_pkg::ADDR_W-1:0] base,
                              input logic [padt_pkg::DATA_W-1:0] bytes);
        wait_idle();
        write_reg(ADDR_REGION_BASE, base);
        write_reg(ADDR_REGION_BYTES, bytes);
        check_reg(ADDR_REGION_BASE);
        check_reg(ADDR_REGION_BYTES);
    endtask

    task automatic test_after_reset();
        send_item(mk_item(padt_pkg::FN_QUERY, '0, '0));
        send_item(mk_item(padt_pkg::FN_MARK_DIRTY, '1, '1));
        send_item(mk_item(padt_pkg::FN_FIND, '0, '0));
        send_item(mk_item(FN_SPARE_6, '1, '1));
    endtask

    task automatic test_region_edges();
        logic [padt_pkg::ADDR_W-1:0] b;
        b = 64'h0000_0000_8000_0000;
        set_region(b, 64'(4097));
        send_item(mk_item(padt_pkg::FN_MARK_ACC, b, '0));
        send_item(mk_item(padt_pkg::FN_MARK_DIRTY, b + 64'd4096, '0));
        send_item(mk_item(padt_pkg::FN_MARK_ACC, b + 64'd4097, '0));
        send_item(mk_item(padt_pkg::FN_QUERY, b - 64'd1, '0));
        send_item(mk_item(padt_pkg::FN_MARK_DIRTY, b + 64'd4096, '0));
        send_item(mk_item(padt_pkg::FN_FIND, '0, '0));
        send_item(mk_item(padt_pkg::FN_FIND, '0, 12'd2));
        send_item(mk_item(padt_pkg::FN_CLR_DIRTY, '0, '0));
        send_item(mk_item(padt_pkg::FN_QUERY, b, '0));
        send_item(mk_item(padt_pkg::FN_CLR_ALL, '0, '0));
        send_item(mk_item(padt_pkg::FN_QUERY, b, '0));
    endtask

    task automatic test_top_of_space();
        set_region(64'hFFFF_FFFF_FFFF_E000, '1);
        send_item(mk_item(padt_pkg::FN_MARK_DIRTY, '1, '0));
        send_item(mk_item(padt_pkg::FN_MARK_DIRTY, '0, '0));
        send_item(mk_item(padt_pkg::FN_FIND, '0, '0));
        send_item(mk_item(padt_pkg::FN_FIND, '0, '1));
        send_item(mk_item(FN_SPARE_7, '0, '0));
    endtask

    task automatic test_full_region();
        set_region('0, 64'(padt_pkg::CAP_BYTES));
        send_item(mk_item(padt_pkg::FN_MARK_DIRTY, 64'h0000_0000_00FF_FFFF, '0));
        send_item(mk_item(padt_pkg::FN_FIND, '0, '0));
        send_item(mk_item(padt_pkg::FN_FIND, '0, '1));
    endtask

    task automatic random_item();
        padt_pkg::t_item             it;
        int                          r;
        int unsigned                 pages;
        logic [padt_pkg::ADDR_W-1:0] addr;
        pages = page_total();
        r = $urandom_range(0, 99);
        if (r < 35) it.func = padt_pkg::FN_MARK_DIRTY;
        else if (r < 58) it.func = padt_pkg::FN_MARK_ACC;
        else if (r < 76) it.func = padt_pkg::FN_QUERY;
        else if (r < 92) it.func = padt_pkg::FN_FIND;
        else if (r < 95) it.func = padt_pkg::FN_CLR_DIRTY;
        else if (r < 96) it.func = padt_pkg::FN_CLR_ALL;
        else if (r < 98) it.func = ($urandom_range(0, 1) != 0) ? FN_SPARE_6 : FN_SPARE_7;
        else it.func = 3'($urandom);
        r = $urandom_range(0, 99);
        if (trk_bytes == 0 || r < 10) addr = rand64();
        else if (r < 14) addr = trk_base - 64'd1;
        else if (r < 18) addr = trk_base + padt_pkg::ADDR_W'(trk_bytes);
        else if (r < 22) addr = trk_base + padt_pkg::ADDR_W'(trk_bytes) - 64'd1;
        else addr = trk_base + padt_pkg::ADDR_W'($urandom_range(0, trk_bytes - 1));
        it.page_address = addr;
        r = $urandom_range(0, 99);
        if (it.func != padt_pkg::FN_FIND || r < 20)
            it.start_index = padt_pkg::IDX_W'($urandom);
        else if (r < 60 || pages == 0) it.start_index = '0;
        else it.start_index = padt_pkg::IDX_W'($urandom_range(0, pages));
        send_item(it);
    endtask

    task automatic test_random_phases();
        int n;
        for (int ph = 0; ph < 6; ph++) begin
            unique case (ph)
                0: set_region(rand64(), 64'($urandom_range(1, 65536)));
                1: set_region('0, 64'(padt_pkg::CAP_BYTES));
                2: set_region(rand64(), 64'($urandom_range(1, 100)));
                3: set_region(64'hFFFF_FFFF_FF80_0000 | 64'($urandom_range(0, 4095)), '1);
                4: set_region(rand64(), 64'(25'($urandom)));
                default: set_region(rand64(), 64'($urandom_range(4096, 40000)));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                no_gaps = (n >= 10 && n < 30);
                if (n == 40) wait_idle();
                random_item();
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        errors    = 0;
        cycles    = 0;
        no_gaps   = 1'b0;
        trk_base  = '0;
        trk_bytes = '0;
        clear_maps(1'b0);
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        item_in <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_region_edges();
        test_top_of_space();
        test_full_region();
        test_random_phases();

        wait_idle();
        repeat (80) @(posedge i_clk);
        errors += expected_q.size();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
